// File: src/slpg_pkg.sv
// ----------------------------------------------------------------------------
// slpg_pkg: shared types and constants of the stepwise line pixel generator
// Holds register indexes, reset values, item mode codes, direction codes and
// the configuration bundle that the back end reads.
// ----------------------------------------------------------------------------
`default_nettype none

package slpg_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] REG_PIXEL_FORMAT  = 2'd2;
	localparam logic [1:0] REG_FRAME_BASE    = 2'd3;

	localparam int unsigned CFG_INDEX_BITS = 2;
	localparam int unsigned CFG_DATA_BITS  = 32;
	localparam int unsigned DIM_BITS       = 13;

	// register reset values
	localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 13'd1024;
	localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 13'd768;
	localparam logic                FORMAT_RESET = 1'b1;
	localparam logic [31:0]         BASE_RESET   = 32'd0;

	// pixel formats
	localparam logic FMT_RGB24 = 1'b0;
	localparam logic FMT_RGB32 = 1'b1;

	// item modes
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_STEP  = 1'b1;

	// walk directions (quadrants I..IV)
	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;
	localparam logic [1:0] QUAD_IV  = 2'd3;

	// pixel queue between walker and address pipeline
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_BITS   = 2;
	localparam int unsigned QCNT_BITS   = 3;

	typedef struct packed {
		logic [DIM_BITS-1:0] screen_width;
		logic [DIM_BITS-1:0] screen_height;
		logic                pixel_format;
		logic [31:0]         frame_base;
	} cfg_t;

endpackage

`default_nettype wire

// File: src/slpg_front.sv
// ----------------------------------------------------------------------------
// slpg_front: line walker
// Takes start and step items, keeps the walk state and pushes one pixel
// record {last, color, y, x} into the queue per drawing step.
// ----------------------------------------------------------------------------
`default_nettype none

module slpg_front #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic                    mode,
	input  wire logic [COORD_BITS-1:0]   start_x,
	input  wire logic [COORD_BITS-1:0]   start_y,
	input  wire logic [COORD_BITS-1:0]   end_x,
	input  wire logic [COORD_BITS-1:0]   end_y,
	input  wire logic [31:0]             draw_color,
	input  wire logic                    q_full,
	output logic                         push,
	output logic [2*COORD_BITS+32:0]     push_data
);

	localparam int EW = COORD_BITS + 2;
	localparam int SW = COORD_BITS + 1;

	logic [COORD_BITS-1:0] cur_x_q, cur_y_q, delta_x_q, delta_y_q;
	logic signed [EW-1:0]  err_q;
	logic [SW-1:0]         steps_q;
	logic [1:0]            quad_q;
	logic [31:0]           color_q;

	logic                  accept, is_step, ahead;
	logic [COORD_BITS-1:0] dx_new, dy_new, nx, ny;
	logic [1:0]            quad_new;
	logic signed [EW-1:0]  dx_e, dy_e, err_nx;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign is_step  = (mode == slpg_pkg::MODE_STEP);
	assign push     = accept && is_step && (steps_q != '0);
	assign push_data = {(steps_q == SW'(1)), color_q, cur_y_q, cur_x_q};

	// start: distances and direction
	always_comb begin
		dx_new = (end_x >= start_x) ? (end_x - start_x) : (start_x - end_x);
		dy_new = (end_y >= start_y) ? (end_y - start_y) : (start_y - end_y);
		if (end_x > start_x && end_y >= start_y) begin
			quad_new = slpg_pkg::QUAD_I;
		end else if (end_x <= start_x && end_y > start_y) begin
			quad_new = slpg_pkg::QUAD_II;
		end else if (end_x < start_x && end_y <= start_y) begin
			quad_new = slpg_pkg::QUAD_III;
		end else if (end_y < start_y) begin
			quad_new = slpg_pkg::QUAD_IV;
		end else begin
			quad_new = slpg_pkg::QUAD_I;
		end
	end

	// step: one unit move chosen by the sign of the error term
	assign dx_e  = signed'({2'b00, delta_x_q});
	assign dy_e  = signed'({2'b00, delta_y_q});
	assign ahead = !err_q[EW-1];

	always_comb begin
		nx     = cur_x_q;
		ny     = cur_y_q;
		err_nx = err_q;
		case (quad_q)
			slpg_pkg::QUAD_I: begin
				if (ahead) begin nx = cur_x_q + 1'b1; err_nx = err_q - dy_e; end
				else begin ny = cur_y_q + 1'b1; err_nx = err_q + dx_e; end
			end
			slpg_pkg::QUAD_II: begin
				if (ahead) begin ny = cur_y_q + 1'b1; err_nx = err_q - dx_e; end
				else begin nx = cur_x_q - 1'b1; err_nx = err_q + dy_e; end
			end
			slpg_pkg::QUAD_III: begin
				if (ahead) begin nx = cur_x_q - 1'b1; err_nx = err_q - dy_e; end
				else begin ny = cur_y_q - 1'b1; err_nx = err_q + dx_e; end
			end
			default: begin
				if (ahead) begin ny = cur_y_q - 1'b1; err_nx = err_q - dx_e; end
				else begin nx = cur_x_q + 1'b1; err_nx = err_q + dy_e; end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			delta_x_q <= '0;
			delta_y_q <= '0;
			err_q     <= '0;
			steps_q   <= '0;
			quad_q    <= slpg_pkg::QUAD_I;
			color_q   <= '0;
		end else if (accept) begin
			if (!is_step) begin
				cur_x_q   <= start_x;
				cur_y_q   <= start_y;
				delta_x_q <= dx_new;
				delta_y_q <= dy_new;
				err_q     <= '0;
				steps_q   <= {1'b0, dx_new} + {1'b0, dy_new};
				quad_q    <= quad_new;
				color_q   <= draw_color;
			end else if (steps_q != '0) begin
				cur_x_q <= nx;
				cur_y_q <= ny;
				err_q   <= err_nx;
				steps_q <= steps_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (steps_q == $past(steps_q) - 1'b1))
		else $error("walker: step count did not drop after a pixel");
	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_step && steps_q == '0) |=> $stable(cur_x_q) && $stable(cur_y_q))
		else $error("walker: idle step moved the position");
`endif

endmodule

`default_nettype wire

// File: src/slpg_queue.sv
// ----------------------------------------------------------------------------
// slpg_queue: short pixel queue
// Small register FIFO that lets the walker and the address pipeline stall
// independently.
// ----------------------------------------------------------------------------
`default_nettype none

module slpg_queue #(
	parameter int WIDTH = 57
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  full,
	output logic                  empty
);

	logic [WIDTH-1:0]                 mem_q [slpg_pkg::QUEUE_DEPTH];
	logic [slpg_pkg::QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [slpg_pkg::QCNT_BITS-1:0]   count_q;

	assign full    = (count_q == slpg_pkg::QCNT_BITS'(slpg_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full)
		else $error("queue: write while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !empty)
		else $error("queue: read while empty");
`endif

endmodule

`default_nettype wire

// File: src/slpg_back.sv
// ----------------------------------------------------------------------------
// slpg_back: address pipeline
// Pops pixel records and forms clip flag, color and byte address over four
// stages; the last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slpg_back #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire slpg_pkg::cfg_t        cfg,
	input  wire logic                  q_empty,
	input  wire logic [2*COORD_BITS+32:0] q_data,
	output logic                       q_pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [COORD_BITS-1:0]      pixel_x,
	output logic [COORD_BITS-1:0]      pixel_y,
	output logic [31:0]                byte_address,
	output logic [31:0]                pixel_color,
	output logic                       on_screen,
	output logic                       last
);

	localparam int PW = COORD_BITS + slpg_pkg::DIM_BITS;

	logic                  en;
	logic [COORD_BITS-1:0] qx, qy;
	logic [31:0]           qcolor;
	logic                  qlast;
	logic [PW-1:0]         prod;

	logic                  v_s1, v_s2, v_s3, v_s4;
	logic [COORD_BITS-1:0] x_s1, x_s2, x_s3, x_s4;
	logic [COORD_BITS-1:0] y_s1, y_s2, y_s3, y_s4;
	logic [31:0]           c_s1, c_s2, c_s3, c_s4;
	logic                  l_s1, l_s2, l_s3, l_s4;
	logic                  o_s1, o_s2, o_s3, o_s4;
	logic [PW-1:0]         prod_s1;
	logic [31:0]           idx_s2, scaled_s3, addr_s4;

	assign {qlast, qcolor, qy, qx} = q_data;
	assign en    = !v_s4 || !out_stall;
	assign q_pop = en && !q_empty;
	assign prod  = PW'(qy) * PW'(cfg.screen_width);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= q_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: row multiply, clip test, color format
			prod_s1 <= prod;
			x_s1    <= qx;
			y_s1    <= qy;
			l_s1    <= qlast;
			o_s1    <= (32'(qx) < 32'(cfg.screen_width)) &&
			           (32'(qy) < 32'(cfg.screen_height));
			c_s1    <= (cfg.pixel_format == slpg_pkg::FMT_RGB32) ? qcolor :
			           {8'h00, qcolor[23:0]};
			// s2: pixel index
			idx_s2 <= 32'(prod_s1) + 32'(x_s1);
			x_s2 <= x_s1; y_s2 <= y_s1; c_s2 <= c_s1; l_s2 <= l_s1; o_s2 <= o_s1;
			// s3: bytes per pixel
			scaled_s3 <= (cfg.pixel_format == slpg_pkg::FMT_RGB32) ? {idx_s2[29:0], 2'b00} :
			             idx_s2 + {idx_s2[30:0], 1'b0};
			x_s3 <= x_s2; y_s3 <= y_s2; c_s3 <= c_s2; l_s3 <= l_s2; o_s3 <= o_s2;
			// s4: frame base, output register
			addr_s4 <= cfg.frame_base + scaled_s3;
			x_s4 <= x_s3; y_s4 <= y_s3; c_s4 <= c_s3; l_s4 <= l_s3; o_s4 <= o_s3;
		end
	end

	assign out_valid    = v_s4;
	assign pixel_x      = x_s4;
	assign pixel_y      = y_s4;
	assign byte_address = addr_s4;
	assign pixel_color  = c_s4;
	assign on_screen    = o_s4;
	assign last         = l_s4;

`ifndef ASSERT_OFF
	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && on_screen) |->
		(32'(pixel_x) < 32'(cfg.screen_width)) && (32'(pixel_y) < 32'(cfg.screen_height)))
		else $error("back: on-screen flag disagrees with clip limits");
`endif

endmodule

`default_nettype wire

// File: src/stepwise_line_pixel_generator_unit.sv
// ----------------------------------------------------------------------------
// stepwise_line_pixel_generator_unit: line pixel generator top level
// Walks a line one unit move per step item and emits frame-buffer pixel
// writes with address, color, clip flag and last flag.
// ----------------------------------------------------------------------------
// A start item (mode 0) loads both endpoints and the color and gives no
// result; a step item (mode 1) emits the pixel at the current position and
// moves one unit in x or y by the point-by-point comparison rule, so a line
// takes |dx|+|dy| steps, the start point is drawn and the end point is not.
// Steps beyond the end give nothing. Items are taken one per cycle while the
// queue is not full: the walker updates its state in the accepting cycle and
// drops each pixel into a four-entry queue, and a four-stage address pipeline
// (row multiply, index add, 3/4 byte scale, base add into the output
// register) drains it. The input stalls only when the queue is full; the
// output register holds under out_stall.
// Registers: 0 screen_width, 1 screen_height, 2 pixel_format (0 = 3 bytes,
// 1 = 4 bytes per pixel), 3 frame_base; write them only while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module stepwise_line_pixel_generator_unit #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_we,
	input  wire logic [slpg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [slpg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	// input channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  mode,
	input  wire logic [COORD_BITS-1:0] start_x,
	input  wire logic [COORD_BITS-1:0] start_y,
	input  wire logic [COORD_BITS-1:0] end_x,
	input  wire logic [COORD_BITS-1:0] end_y,
	input  wire logic [31:0]           draw_color,
	// output channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [COORD_BITS-1:0]      pixel_x,
	output logic [COORD_BITS-1:0]      pixel_y,
	output logic [31:0]                byte_address,
	output logic [31:0]                pixel_color,
	output logic                       on_screen,
	output logic                       last
);

	// pixel record: {last, color, y, x}
	localparam int QW = 2 * COORD_BITS + 33;

	slpg_pkg::cfg_t cfg_q;

	logic          push, pop, q_full, q_empty;
	logic [QW-1:0] push_data, pop_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= slpg_pkg::WIDTH_RESET;
			cfg_q.screen_height <= slpg_pkg::HEIGHT_RESET;
			cfg_q.pixel_format  <= slpg_pkg::FORMAT_RESET;
			cfg_q.frame_base    <= slpg_pkg::BASE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				slpg_pkg::REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[12:0];
				slpg_pkg::REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[12:0];
				slpg_pkg::REG_PIXEL_FORMAT:  cfg_q.pixel_format  <= cfg_data[0];
				slpg_pkg::REG_FRAME_BASE:    cfg_q.frame_base    <= cfg_data;
				default:                     cfg_q               <= cfg_q;
			endcase
		end
	end

	// walker: takes items, keeps position / error term / remaining steps
	slpg_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.draw_color (draw_color),
		.q_full     (q_full),
		.push       (push),
		.push_data  (push_data)
	);

	// decoupling queue
	slpg_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (push_data),
		.rd_en   (pop),
		.rd_data (pop_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	// address pipeline and output register
	slpg_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_data       (pop_data),
		.q_pop        (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.byte_address (byte_address),
		.pixel_color  (pixel_color),
		.on_screen    (on_screen),
		.last         (last)
	);

endmodule

`default_nettype wire
